### rtl/srs_pkg.sv
// shared types, constants and codes for the segmented range splitter
package srs_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF  = 24;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SPLIT  = 2'd2
  } srs_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } srs_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RESP,
    S_BASE,
    S_LEFT,
    S_RIGHT,
    S_CHUNK
  } srs_state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_C,
    IDX_ZERO,
    IDX_DEC,
    IDX_INC
  } srs_idx_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] segment_size;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] request_length;
  } srs_in_t;

  typedef struct packed {
    logic [ID_W-1:0]     segment_id;
    logic [FIELD_W-1:0]  local_offset;
    logic [FIELD_W-1:0]  chunk_length;
    logic [STATUS_W-1:0] status;
    logic                last;
  } srs_out_t;

  // controller to datapath
  typedef struct packed {
    logic        req_ld;
    logic        tbl_clear;
    logic        tbl_append;
    logic        split_init;
    srs_idx_op_e idx_op;
    logic        cache_ld;
    logic        rd_en;
    logic        rd_prev;
    logic        start_ld;
    logic        start_clr;
    logic        adv;
    logic        out_ld;
    logic        out_chunk;
    srs_status_e resp_status;
  } srs_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             size_zero;
    logic             no_room;
    logic             len_zero;
    logic             range_err;
    logic             c_zero;
    logic             idx_one;
    logic             off_ge_rd;
    logic             take;
    logic             out_free;
  } srs_sts_t;

endpackage

### rtl/segmented_range_splitter.sv
// segmented range splitter top level: controller plus datapath
// clear, append and rejected or empty requests give one result record, and the next transaction
// is taken only once that result is loaded; split: the search starts from the cached segment
// and walks left or right one segment at a time until it reaches the segment that holds the
// start offset; then one chunk per unstalled cycle
// reset clears segment count, total and cache; table contents are left unwritten
module segmented_range_splitter
  import srs_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  srs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output srs_out_t out_data_o
);

  srs_ctl_t ctl;
  srs_sts_t sts;

  srs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  srs_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule

### rtl/srs_ram.sv
// generic single write port, single read port ram with registered read
module srs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/srs_ctrl.sv
// controller state machine: command decode, segment search and chunk sequencing
module srs_ctrl
  import srs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  srs_sts_t sts_i,
  output srs_ctl_t ctl_o
);

  srs_state_e  state_q, state_d;
  srs_status_e resp_q, resp_d;
  srs_status_e st;
  logic        respond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    st      = ST_OK;
    respond = 1'b0;
    ctl_o   = '0;
    ctl_o.idx_op      = IDX_HOLD;
    ctl_o.resp_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.req_ld = 1'b1;
          state_d      = S_CHECK;
        end
      end

      S_CHECK: begin
        case (sts_i.command)
          CMD_CLEAR: begin
            ctl_o.tbl_clear = 1'b1;
            respond         = 1'b1;
          end
          CMD_APPEND: begin
            respond = 1'b1;
            if (sts_i.size_zero) begin
              st = ST_ZERO;
            end else if (sts_i.no_room) begin
              st = ST_FULL;
            end else begin
              ctl_o.tbl_append = 1'b1;
            end
          end
          CMD_SPLIT: begin
            if (sts_i.len_zero) begin
              respond = 1'b1;
            end else if (sts_i.range_err) begin
              respond = 1'b1;
              st      = ST_RANGE;
            end else begin
              ctl_o.split_init = 1'b1;
              ctl_o.rd_en      = 1'b1;
              if (sts_i.c_zero) begin
                ctl_o.idx_op = IDX_ZERO;
                state_d      = S_RIGHT;
              end else begin
                // fetch the start of the cached segment first
                ctl_o.idx_op  = IDX_LOAD_C;
                ctl_o.rd_prev = 1'b1;
                state_d       = S_BASE;
              end
            end
          end
          default: begin
            respond = 1'b1;
            st      = ST_RANGE;
          end
        endcase
        if (respond) begin
          resp_d = st;
          if (sts_i.out_free) begin
            ctl_o.out_ld      = 1'b1;
            ctl_o.resp_status = st;
            state_d           = S_IDLE;
          end else begin
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_ld      = 1'b1;
          ctl_o.resp_status = resp_q;
          state_d           = S_IDLE;
        end
      end

      S_BASE: begin
        if (sts_i.off_ge_rd) begin
          ctl_o.start_ld = 1'b1;
          ctl_o.rd_en    = 1'b1;
          state_d        = S_RIGHT;
        end else if (sts_i.idx_one) begin
          ctl_o.idx_op    = IDX_ZERO;
          ctl_o.start_clr = 1'b1;
          ctl_o.rd_en     = 1'b1;
          ctl_o.cache_ld  = 1'b1;
          state_d         = S_CHUNK;
        end else begin
          ctl_o.idx_op  = IDX_DEC;
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_prev = 1'b1;
          state_d       = S_LEFT;
        end
      end

      S_LEFT: begin
        if (sts_i.off_ge_rd) begin
          ctl_o.start_ld = 1'b1;
          ctl_o.rd_en    = 1'b1;
          ctl_o.cache_ld = 1'b1;
          state_d        = S_CHUNK;
        end else if (sts_i.idx_one) begin
          ctl_o.idx_op    = IDX_ZERO;
          ctl_o.start_clr = 1'b1;
          ctl_o.rd_en     = 1'b1;
          ctl_o.cache_ld  = 1'b1;
          state_d         = S_CHUNK;
        end else begin
          ctl_o.idx_op  = IDX_DEC;
          ctl_o.rd_en   = 1'b1;
          ctl_o.rd_prev = 1'b1;
        end
      end

      S_RIGHT: begin
        if (!sts_i.off_ge_rd) begin
          // read data already holds the end of the hit segment
          ctl_o.cache_ld = 1'b1;
          state_d        = S_CHUNK;
        end else begin
          ctl_o.start_ld = 1'b1;
          ctl_o.idx_op   = IDX_INC;
          ctl_o.rd_en    = 1'b1;
        end
      end

      S_CHUNK: begin
        if (sts_i.out_free) begin
          ctl_o.out_ld    = 1'b1;
          ctl_o.out_chunk = 1'b1;
          if (sts_i.take) begin
            state_d = S_IDLE;
          end else begin
            ctl_o.adv    = 1'b1;
            ctl_o.idx_op = IDX_INC;
            ctl_o.rd_en  = 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/srs_dp.sv
// datapath: request register, segment end table, search and chunk arithmetic, output register
module srs_dp
  import srs_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  srs_in_t  in_data_i,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output srs_out_t out_data_o,
  input  srs_ctl_t ctl_i,
  output srs_sts_t sts_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SUM_W = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 1;

  srs_in_t                req_q;
  logic [CNT_W-1:0]       count_q;
  logic [OFFSET_BITS-1:0] total_q;
  logic [IDX_W-1:0]       cache_q;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [OFFSET_BITS-1:0] start_q, pos_q, rem_q;
  srs_out_t               out_q;
  logic                   out_valid_q;

  logic [IDX_W-1:0]       c_eff;
  logic [SUM_W-1:0]       app_sum, rng_sum;
  logic [OFFSET_BITS-1:0] rdata, avail, chunk, local_off;
  logic [IDX_W-1:0]       raddr, waddr;
  logic                   take, out_free;

  srs_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(MAX_SEGMENTS)
  ) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.tbl_append),
    .waddr_i(waddr),
    .wdata_i(app_sum[OFFSET_BITS-1:0]),
    .re_i   (ctl_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign waddr = count_q[IDX_W-1:0];

  // a stale cache beyond the table falls back to the first segment
  assign c_eff = (CNT_W'(cache_q) >= count_q) ? '0 : cache_q;

  assign app_sum = SUM_W'(total_q) + SUM_W'(req_q.segment_size);
  assign rng_sum = SUM_W'(req_q.start_offset) + SUM_W'(req_q.request_length);

  always_comb begin
    case (ctl_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_LOAD_C: idx_d = c_eff;
      IDX_ZERO:   idx_d = '0;
      IDX_DEC:    idx_d = idx_q - IDX_W'(1);
      IDX_INC:    idx_d = idx_q + IDX_W'(1);
      default:    idx_d = idx_q;
    endcase
  end

  assign raddr = ctl_i.rd_prev ? (idx_d - IDX_W'(1)) : idx_d;

  // rdata holds the end of the current segment while chunking
  assign avail     = rdata - pos_q;
  assign take      = (rem_q <= avail);
  assign chunk     = take ? rem_q : avail;
  assign local_off = pos_q - start_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o           = '0;
    sts_o.command   = req_q.command;
    sts_o.size_zero = (req_q.segment_size == '0);
    sts_o.no_room   = (count_q == CNT_W'(MAX_SEGMENTS)) || (|app_sum[SUM_W-1:OFFSET_BITS]);
    sts_o.len_zero  = (req_q.request_length == '0);
    sts_o.range_err = (rng_sum > SUM_W'(total_q));
    sts_o.c_zero    = (c_eff == '0);
    sts_o.idx_one   = (idx_q == IDX_W'(1));
    sts_o.off_ge_rd = (pos_q >= rdata);
    sts_o.take      = take;
    sts_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      cache_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.tbl_clear) begin
        count_q <= '0;
        total_q <= '0;
        cache_q <= '0;
      end else begin
        if (ctl_i.tbl_append) begin
          count_q <= count_q + CNT_W'(1);
          total_q <= app_sum[OFFSET_BITS-1:0];
        end
        if (ctl_i.cache_ld) begin
          cache_q <= idx_d;
        end
      end
      if (ctl_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.req_ld) begin
      req_q <= in_data_i;
    end
    idx_q <= idx_d;
    if (ctl_i.split_init || ctl_i.start_clr) begin
      start_q <= '0;
    end else if (ctl_i.start_ld || ctl_i.adv) begin
      start_q <= rdata;
    end
    if (ctl_i.split_init) begin
      pos_q <= OFFSET_BITS'(req_q.start_offset);
      rem_q <= OFFSET_BITS'(req_q.request_length);
    end else if (ctl_i.adv) begin
      pos_q <= rdata;
      rem_q <= rem_q - avail;
    end
    if (ctl_i.out_ld) begin
      if (ctl_i.out_chunk) begin
        out_q.segment_id   <= ID_W'(idx_q);
        out_q.local_offset <= FIELD_W'(local_off);
        out_q.chunk_length <= FIELD_W'(chunk);
        out_q.status       <= ST_OK;
        out_q.last         <= take;
      end else begin
        out_q.segment_id   <= '0;
        out_q.local_offset <= '0;
        out_q.chunk_length <= '0;
        out_q.status       <= ctl_i.resp_status;
        out_q.last         <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
